### hdl/rectangle_hit_test_table_assert.svh
// Assertion macros used by the checker file.
`ifndef RECTANGLE_HIT_TEST_TABLE_ASSERT_SVH
`define RECTANGLE_HIT_TEST_TABLE_ASSERT_SVH

// Same-cycle implication, idle while reset is high.
`define RHTT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rhtt assertion failed");

// Next-cycle implication, idle while reset is high.
`define RHTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rhtt assertion failed");

`endif

### hdl/rhtt_pkg.sv
package rhtt_pkg;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_NO_HIT    = 2'd3;

  localparam int ID_W    = 10;
  localparam int POS_W   = 12;
  localparam int SIZE_W  = 11;
  localparam int COUNT_W = 5;

  // One table row as stored in memory.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] height;
    logic [SIZE_W-1:0] width;
    logic [POS_W-1:0]  top;
    logic [POS_W-1:0]  left;
  } entry_t;

endpackage

### hdl/rectangle_hit_test_table.sv
// Channel  Dir  tdata (low bit up)                                   tuser
// s_axis   in   region_id[9:0] pos_x[21:10] pos_y[33:22]             command[1:0]
//               rect_width[44:34] rect_height[55:45]
// m_axis   out  hit_id[9:0] entry_count[14:10] zero[15]              status[1:0]
//
// Add, unused codes and empty-table commands go from IDLE straight to FINISH.
// Lookup and remove scan the entry memory one row per cycle (one registered
// read port): lookup stops at the first hit, lowest row first, or after count
// rows; remove, on an id match, moves each later row down one place, then decrements count.
// rst is synchronous and clears count and the control state; the memory is
// not cleared. A stalled output holds the block in its final state until taken.
module rectangle_hit_test_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // region_id, pos_x, pos_y, rect_width, rect_height
  input  logic [1:0]  s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // hit_id, entry_count, zero pad
  output logic [1:0]  m_axis_tuser    // status
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [1:0] {IDLE, SCAN, SHIFT, FINISH} state_t;

  state_t state;

  logic [1:0]                  cmd;
  logic [rhtt_pkg::ID_W-1:0]   req_id;
  logic [rhtt_pkg::POS_W-1:0]  req_x;
  logic [rhtt_pkg::POS_W-1:0]  req_y;
  logic [CW-1:0]               count;
  logic [CW-1:0]               idx;
  logic [1:0]                  res_status;
  logic [rhtt_pkg::ID_W-1:0]   res_hit;

  logic [1:0]                  out_status;
  logic [rhtt_pkg::ID_W-1:0]   out_hit;
  logic [rhtt_pkg::COUNT_W-1:0] out_count;

  rhtt_pkg::entry_t mem [TABLE_DEPTH];
  rhtt_pkg::entry_t rd_data;
  rhtt_pkg::entry_t wr_data;
  logic [IW-1:0]    rd_addr;
  logic [IW-1:0]    wr_addr;
  logic             wr_en;

  logic [CW:0] idx_p1;
  logic [CW:0] idx_p2;
  logic        last_row;
  logic        hit;
  logic        id_match;
  logic        out_free;
  logic        s_accept;

  logic signed [rhtt_pkg::POS_W:0] px_ext;
  logic signed [rhtt_pkg::POS_W:0] py_ext;
  logic signed [rhtt_pkg::POS_W:0] left_ext;
  logic signed [rhtt_pkg::POS_W:0] top_ext;
  logic signed [rhtt_pkg::POS_W:0] right_ext;
  logic signed [rhtt_pkg::POS_W:0] bottom_ext;

  assign s_axis_tready = (state == IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign idx_p1   = {1'b0, idx} + (CW+1)'(1);
  assign idx_p2   = {1'b0, idx} + (CW+1)'(2);
  assign last_row = (idx_p1 >= {1'b0, count});

  // Open-interior containment, sums one bit wider than the edges.
  assign px_ext     = $signed({req_x[rhtt_pkg::POS_W-1], req_x});
  assign py_ext     = $signed({req_y[rhtt_pkg::POS_W-1], req_y});
  assign left_ext   = $signed({rd_data.left[rhtt_pkg::POS_W-1], rd_data.left});
  assign top_ext    = $signed({rd_data.top[rhtt_pkg::POS_W-1], rd_data.top});
  assign right_ext  = left_ext + $signed({2'b00, rd_data.width});
  assign bottom_ext = top_ext + $signed({2'b00, rd_data.height});
  assign hit = (px_ext > left_ext) && (px_ext < right_ext) &&
               (py_ext > top_ext) && (py_ext < bottom_ext);
  assign id_match = (rd_data.id == req_id);

  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = count[IW-1:0];
    wr_data = rd_data;
    case (state)
      IDLE: begin
        if (s_accept && s_axis_tuser == rhtt_pkg::CMD_ADD && count < DEPTH_C) begin
          wr_en        = 1'b1;
          wr_data.id   = s_axis_tdata[9:0];
          wr_data.left = s_axis_tdata[21:10];
          wr_data.top  = s_axis_tdata[33:22];
          wr_data.width  = s_axis_tdata[44:34];
          wr_data.height = s_axis_tdata[55:45];
        end
      end
      SCAN: rd_addr = idx_p1[IW-1:0];
      SHIFT: begin
        // move row idx+1 down to idx while fetching idx+2
        rd_addr = idx_p2[IW-1:0];
        if (!last_row) begin
          wr_en   = 1'b1;
          wr_addr = idx[IW-1:0];
        end
      end
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      count         <= '0;
      idx           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // FINISH loads the next result itself
      if (m_axis_tvalid && m_axis_tready && state != FINISH) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_accept) begin
            cmd     <= s_axis_tuser;
            req_id  <= s_axis_tdata[9:0];
            req_x   <= s_axis_tdata[21:10];
            req_y   <= s_axis_tdata[33:22];
            idx     <= '0;
            res_hit <= '0;
            res_status <= rhtt_pkg::ST_DONE;
            state   <= FINISH;
            case (s_axis_tuser)
              rhtt_pkg::CMD_ADD: begin
                if (count >= DEPTH_C) begin
                  res_status <= rhtt_pkg::ST_FULL;
                end else begin
                  count <= count + CW'(1);
                end
              end
              rhtt_pkg::CMD_REMOVE: begin
                if (count == '0) begin
                  res_status <= rhtt_pkg::ST_NOT_FOUND;
                end else begin
                  state <= SCAN;
                end
              end
              rhtt_pkg::CMD_LOOKUP: begin
                if (count == '0) begin
                  res_status <= rhtt_pkg::ST_NO_HIT;
                end else begin
                  state <= SCAN;
                end
              end
              default: res_status <= rhtt_pkg::ST_DONE;
            endcase
          end
        end
        SCAN: begin
          if (cmd == rhtt_pkg::CMD_LOOKUP) begin
            if (hit) begin
              res_status <= rhtt_pkg::ST_DONE;
              res_hit    <= rd_data.id;
              state      <= FINISH;
            end else if (last_row) begin
              res_status <= rhtt_pkg::ST_NO_HIT;
              state      <= FINISH;
            end else begin
              idx <= idx_p1[CW-1:0];
            end
          end else begin
            if (id_match) begin
              state <= SHIFT;
            end else if (last_row) begin
              res_status <= rhtt_pkg::ST_NOT_FOUND;
              state      <= FINISH;
            end else begin
              idx <= idx_p1[CW-1:0];
            end
          end
        end
        SHIFT: begin
          if (last_row) begin
            count      <= count - CW'(1);
            res_status <= rhtt_pkg::ST_DONE;
            state      <= FINISH;
          end else begin
            idx <= idx_p1[CW-1:0];
          end
        end
        FINISH: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            out_status    <= res_status;
            out_hit       <= res_hit;
            out_count     <= rhtt_pkg::COUNT_W'(count);
            state         <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {1'b0, out_count, out_hit};
  assign m_axis_tuser = out_status;

endmodule

### hdl/rhtt_checker.sv
`include "rectangle_hit_test_table_assert.svh"

module rhtt_checker #(
  parameter int TABLE_DEPTH = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [55:0] s_axis_tdata,   // region_id, pos_x, pos_y, rect_width, rect_height
  input logic [1:0]  s_axis_tuser,   // command
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,   // hit_id, entry_count, zero pad
  input logic [1:0]  m_axis_tuser    // status
);

  localparam logic [4:0] DEPTH_LOW = 5'(TABLE_DEPTH);

  logic in_xfer;
  logic stalled;

  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign stalled = m_axis_tvalid && !m_axis_tready;

  `RHTT_ASSERT_NEXT(a_out_hold, clk, rst, stalled, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  // one item in flight: the input side closes right after a transfer
  `RHTT_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_xfer, !s_axis_tready)
  `RHTT_ASSERT_NOW(a_hit_id_zero, clk, rst, m_axis_tvalid && m_axis_tuser != rhtt_pkg::ST_DONE, m_axis_tdata[9:0] == 10'd0)
  `RHTT_ASSERT_NOW(a_full_count, clk, rst, m_axis_tvalid && m_axis_tuser == rhtt_pkg::ST_FULL, m_axis_tdata[14:10] == DEPTH_LOW)
  `RHTT_ASSERT_NOW(a_count_range, clk, rst, m_axis_tvalid, (TABLE_DEPTH > 31) || (m_axis_tdata[14:10] <= DEPTH_LOW))

endmodule

bind rectangle_hit_test_table rhtt_checker #(
  .TABLE_DEPTH(TABLE_DEPTH)
) u_rhtt_checker (
  .clk(clk),
  .rst(rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata(s_axis_tdata),
  .s_axis_tuser(s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata),
  .m_axis_tuser(m_axis_tuser)
);
